// ===== hw/rtl/spbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_pkg
// Shared types and constants for the sleep package byte parser.
// ----------------------------------------------------------------------------
package spbp_pkg;

    localparam logic [7:0] NAME_OP     = 8'h08;
    localparam logic [7:0] ROOT_CHAR   = 8'h5C;
    localparam logic [7:0] PACKAGE_OP  = 8'h12;
    localparam logic [7:0] BYTE_PREFIX = 8'h0A;
    localparam logic [7:0] WORD_PREFIX = 8'h0B;
    localparam logic [7:0] CHAR_US     = 8'h5F;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_5      = 8'h35;

    localparam int unsigned HIST_BYTES = 6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_B_MISSING = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [3:0] PH_SCAN     = 4'd0;
    localparam logic [3:0] PH_PKG_LEAD = 4'd1;
    localparam logic [3:0] PH_PKG_SKIP = 4'd2;
    localparam logic [3:0] PH_NUM_ELEM = 4'd3;
    localparam logic [3:0] PH_A_SEL    = 4'd4;
    localparam logic [3:0] PH_A_BYTE   = 4'd5;
    localparam logic [3:0] PH_A_WLO    = 4'd6;
    localparam logic [3:0] PH_A_WHI    = 4'd7;
    localparam logic [3:0] PH_B_SEL    = 4'd8;
    localparam logic [3:0] PH_B_BYTE   = 4'd9;
    localparam logic [3:0] PH_B_WLO    = 4'd10;
    localparam logic [3:0] PH_B_WHI    = 4'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [15:0] sleep_type_a;
        logic [15:0] sleep_type_b;
    } t_result;

endpackage

// ===== hw/rtl/spbp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_in_stage
// Input register for body bytes; stalls the sender only when a held byte
// cannot move on because the result register is occupied.
// ----------------------------------------------------------------------------
module spbp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  spbp_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           i_out_free,
    output logic           o_step,
    output spbp_pkg::t_item o_item
);
    import spbp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_step  = r_valid && i_out_free;
    assign o_stall = r_valid && !i_out_free;
    assign o_item  = r_item;

    always_comb begin
        n_valid = o_stall ? 1'b1 : i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/spbp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_parser
// Name window, phase sequencer and value decoder. One byte is consumed per
// step and at most one result is produced on that step.
// ----------------------------------------------------------------------------
module spbp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  spbp_pkg::t_item   i_item,
    output logic              o_emit,
    output spbp_pkg::t_result o_result
);
    import spbp_pkg::*;

    logic [8*HIST_BYTES-1:0] r_hist;
    logic [2:0]              r_hist_cnt;
    logic [3:0]              r_phase;
    logic [1:0]              r_skip;
    logic [15:0]             r_first;
    logic [7:0]              r_low;
    logic                    r_reported;

    logic [8*HIST_BYTES-1:0] n_hist;
    logic [2:0]              n_hist_cnt;
    logic [3:0]              n_phase;
    logic [1:0]              n_skip;
    logic [15:0]             n_first;
    logic [7:0]              n_low;
    logic                    n_reported;

    logic       name_hit;
    logic       emit;
    t_result    result;
    logic [7:0] b;

    assign b = i_item.data_byte;

    // The four name bytes sit in the newest positions of the window, with the
    // name opcode (or opcode plus root prefix) just before them.
    always_comb begin
        name_hit = 1'b0;
        if (r_hist_cnt >= 3'd5 && r_hist[31:24] == CHAR_US && r_hist[23:16] == CHAR_S
            && r_hist[15:8] == CHAR_5 && r_hist[7:0] == CHAR_US) begin
            if (r_hist[39:32] == NAME_OP) begin
                name_hit = 1'b1;
            end else if (r_hist_cnt >= 3'd6 && r_hist[47:40] == NAME_OP
                         && r_hist[39:32] == ROOT_CHAR) begin
                name_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_hist     = r_hist;
        n_hist_cnt = r_hist_cnt;
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_first    = r_first;
        n_low      = r_low;
        n_reported = r_reported;
        emit       = 1'b0;
        result     = '0;

        if (!r_reported) begin
            case (r_phase)
                PH_SCAN: begin
                    if (b == PACKAGE_OP && name_hit) begin
                        n_phase = PH_PKG_LEAD;
                    end
                end
                PH_PKG_LEAD: begin
                    n_skip  = b[7:6];
                    n_phase = (b[7:6] != 2'd0) ? PH_PKG_SKIP : PH_NUM_ELEM;
                end
                PH_PKG_SKIP: begin
                    n_skip = r_skip - 2'd1;
                    if (r_skip == 2'd1) begin
                        n_phase = PH_NUM_ELEM;
                    end
                end
                PH_NUM_ELEM: begin
                    n_phase = PH_A_SEL;
                end
                PH_A_SEL: begin
                    if (b == BYTE_PREFIX) begin
                        n_phase = PH_A_BYTE;
                    end else if (b == WORD_PREFIX) begin
                        n_phase = PH_A_WLO;
                    end else begin
                        n_first = {8'd0, b};
                        n_phase = PH_B_SEL;
                    end
                end
                PH_A_BYTE: begin
                    n_first = {8'd0, b};
                    n_phase = PH_B_SEL;
                end
                PH_A_WLO: begin
                    n_low   = b;
                    n_phase = PH_A_WHI;
                end
                PH_A_WHI: begin
                    n_first = {b, r_low};
                    n_phase = PH_B_SEL;
                end
                PH_B_SEL: begin
                    if (b == BYTE_PREFIX) begin
                        n_phase = PH_B_BYTE;
                    end else if (b == WORD_PREFIX) begin
                        n_phase = PH_B_WLO;
                    end else begin
                        emit   = 1'b1;
                        result = '{parse_status: ST_OK, sleep_type_a: r_first,
                                   sleep_type_b: {8'd0, b}};
                    end
                end
                PH_B_BYTE: begin
                    emit   = 1'b1;
                    result = '{parse_status: ST_OK, sleep_type_a: r_first,
                               sleep_type_b: {8'd0, b}};
                end
                PH_B_WLO: begin
                    n_low   = b;
                    n_phase = PH_B_WHI;
                end
                PH_B_WHI: begin
                    emit   = 1'b1;
                    result = '{parse_status: ST_OK, sleep_type_a: r_first,
                               sleep_type_b: {b, r_low}};
                end
                default: begin
                    n_phase = PH_SCAN;
                end
            endcase
        end

        if (emit) begin
            n_reported = 1'b1;
        end

        n_hist = {r_hist[8*HIST_BYTES-9:0], b};
        if (r_hist_cnt < 3'(HIST_BYTES)) begin
            n_hist_cnt = r_hist_cnt + 3'd1;
        end

        // The end of the table forces a report if none was given, then the
        // whole parser starts over for the next table.
        if (i_item.last_byte) begin
            if (!n_reported) begin
                emit = 1'b1;
                if (n_phase >= PH_B_SEL && n_phase <= PH_B_WHI) begin
                    result = '{parse_status: ST_B_MISSING, sleep_type_a: n_first,
                               sleep_type_b: 16'd0};
                end else begin
                    result = '{parse_status: ST_NOT_FOUND, sleep_type_a: 16'd0,
                               sleep_type_b: 16'd0};
                end
            end
            n_hist     = '0;
            n_hist_cnt = 3'd0;
            n_phase    = PH_SCAN;
            n_skip     = 2'd0;
            n_first    = 16'd0;
            n_low      = 8'd0;
            n_reported = 1'b0;
        end
    end

    assign o_emit   = i_step && emit;
    assign o_result = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_hist_cnt <= 3'd0;
            r_phase    <= PH_SCAN;
            r_skip     <= 2'd0;
            r_first    <= 16'd0;
            r_low      <= 8'd0;
            r_reported <= 1'b0;
        end else if (i_step) begin
            r_hist     <= n_hist;
            r_hist_cnt <= n_hist_cnt;
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_first    <= n_first;
            r_low      <= n_low;
            r_reported <= n_reported;
        end
    end

endmodule

// ===== hw/rtl/spbp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_out_stage
// Result register; holds a word while the receiver stalls.
// ----------------------------------------------------------------------------
module spbp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  spbp_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output spbp_pkg::t_result o_result
);
    import spbp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hw/rtl/sleep_package_byte_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleep_package_byte_parser_unit
// Streams table body bytes and reports the two sleep-type values of the
// S5 package once per table.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   byte in | input     | i_valid / o_stall   | i_data_byte, i_last_byte
//   result  | output    | o_valid / i_stall   | o_parse_status, o_sleep_type_a,
//           |           |                     | o_sleep_type_b
//
// One word is taken every cycle while o_stall is low; a result passes through
// the input register, then the result register.
// The rate is set by the phase update between the two registers.
// Reset clears the valid flags and the parse state; the first table starts
// right after reset.
// o_stall rises only when a byte is held and the result register is still
// occupied by a stalled word.
// ----------------------------------------------------------------------------
module sleep_package_byte_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [1:0]  o_parse_status,
    output logic [15:0] o_sleep_type_a,
    output logic [15:0] o_sleep_type_b,
    input  logic        i_stall
);
    import spbp_pkg::*;

    t_item   in_item;
    t_item   step_item;
    t_result step_result;
    t_result out_result;
    logic    out_free;
    logic    step;
    logic    emit;

    assign in_item = '{data_byte: i_data_byte, last_byte: i_last_byte};

    spbp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (in_item),
        .o_stall    (o_stall),
        .i_out_free (out_free),
        .o_step     (step),
        .o_item     (step_item)
    );

    spbp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (step_item),
        .o_emit   (emit),
        .o_result (step_result)
    );

    spbp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (step_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_parse_status = out_result.parse_status;
    assign o_sleep_type_a = out_result.sleep_type_a;
    assign o_sleep_type_b = out_result.sleep_type_b;

    // A not-found report never carries values.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parse_status == ST_NOT_FOUND)
            |-> (o_sleep_type_a == 16'd0 && o_sleep_type_b == 16'd0))
        else $error("not-found result with nonzero values");

    // A missing second value always reads as zero.
    a_missing_b_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parse_status == ST_B_MISSING) |-> (o_sleep_type_b == 16'd0))
        else $error("missing second value is not zero");

    // The status code stays within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_parse_status == ST_OK || o_parse_status == ST_B_MISSING
                     || o_parse_status == ST_NOT_FOUND))
        else $error("undefined status code");

    // A new result is only loaded while the result register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result loaded over a stalled word");

endmodule

// ===== tb/tb_sleep_package_byte_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sleep_package_byte_parser_unit
// Streams directed and random table bodies into the S5 package parser and
// predicts each sleep-type result in the bench. Results are checked field by
// field in arrival order while both sides idle and stall at random, and the
// receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_sleep_package_byte_parser_unit;
    import spbp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_parse_status;
    logic [15:0] o_sleep_type_a;
    logic [15:0] o_sleep_type_b;
    logic        i_stall = 1'b0;

    sleep_package_byte_parser_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_parse_status (o_parse_status),
        .o_sleep_type_a (o_sleep_type_a),
        .o_sleep_type_b (o_sleep_type_b),
        .i_stall        (i_stall)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Predicted parser state, one table at a time.
    logic [47:0] recent_bytes;
    logic [2:0]  recent_count;
    logic [3:0]  scan_phase;
    logic [1:0]  skip_left;
    logic [15:0] first_val;
    logic [7:0]  low_hold;
    logic        s5_reported;

    t_result     s5_results_due[$];
    logic [7:0]  table_bytes[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    function automatic t_result make_result(input logic [1:0] st, input logic [15:0] a,
                                            input logic [15:0] b);
        t_result r;
        r.parse_status = st;
        r.sleep_type_a = a;
        r.sleep_type_b = b;
        return r;
    endfunction

    task automatic clear_parser();
        recent_bytes = '0;
        recent_count = '0;
        scan_phase   = PH_SCAN;
        skip_left    = '0;
        first_val    = '0;
        low_hold     = '0;
        s5_reported  = 1'b0;
    endtask

    // The package opcode only counts when the five or six bytes before it end in
    // NAME_OP "_S5_", optionally with a root prefix after the opcode.
    function automatic logic s5_name_behind();
        if (recent_count < 3'd5)
            return 1'b0;
        if (recent_bytes[31:0] != {CHAR_US, CHAR_S, CHAR_5, CHAR_US})
            return 1'b0;
        if (recent_bytes[39:32] == NAME_OP)
            return 1'b1;
        return recent_count >= 3'd6 && recent_bytes[47:40] == NAME_OP &&
               recent_bytes[39:32] == ROOT_CHAR;
    endfunction

    task automatic parse_table_byte(input logic [7:0] b, input logic last);
        t_result res;
        logic    fire;
        fire = 1'b0;
        res  = '0;
        if (!s5_reported) begin
            case (scan_phase)
                PH_SCAN: begin
                    if (b == PACKAGE_OP && s5_name_behind())
                        scan_phase = PH_PKG_LEAD;
                end
                PH_PKG_LEAD: begin
                    skip_left  = b[7:6];
                    scan_phase = (b[7:6] != 2'd0) ? PH_PKG_SKIP : PH_NUM_ELEM;
                end
                PH_PKG_SKIP: begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0)
                        scan_phase = PH_NUM_ELEM;
                end
                PH_NUM_ELEM: scan_phase = PH_A_SEL;
                PH_A_SEL: begin
                    if (b == BYTE_PREFIX) begin
                        scan_phase = PH_A_BYTE;
                    end else if (b == WORD_PREFIX) begin
                        scan_phase = PH_A_WLO;
                    end else begin
                        first_val  = {8'h00, b};
                        scan_phase = PH_B_SEL;
                    end
                end
                PH_A_BYTE: begin
                    first_val  = {8'h00, b};
                    scan_phase = PH_B_SEL;
                end
                PH_A_WLO: begin
                    low_hold   = b;
                    scan_phase = PH_A_WHI;
                end
                PH_A_WHI: begin
                    first_val  = {b, low_hold};
                    scan_phase = PH_B_SEL;
                end
                PH_B_SEL: begin
                    if (b == BYTE_PREFIX) begin
                        scan_phase = PH_B_BYTE;
                    end else if (b == WORD_PREFIX) begin
                        scan_phase = PH_B_WLO;
                    end else begin
                        res  = make_result(ST_OK, first_val, {8'h00, b});
                        fire = 1'b1;
                    end
                end
                PH_B_BYTE: begin
                    res  = make_result(ST_OK, first_val, {8'h00, b});
                    fire = 1'b1;
                end
                PH_B_WLO: begin
                    low_hold   = b;
                    scan_phase = PH_B_WHI;
                end
                PH_B_WHI: begin
                    res  = make_result(ST_OK, first_val, {b, low_hold});
                    fire = 1'b1;
                end
                default: scan_phase = PH_SCAN;
            endcase
        end
        if (fire)
            s5_reported = 1'b1;
        recent_bytes = {recent_bytes[39:0], b};
        if (recent_count < 3'd6)
            recent_count = recent_count + 3'd1;
        if (last) begin
            if (!s5_reported) begin
                fire = 1'b1;
                if (scan_phase >= PH_B_SEL && scan_phase <= PH_B_WHI)
                    res = make_result(ST_B_MISSING, first_val, 16'h0000);
                else
                    res = make_result(ST_NOT_FOUND, 16'h0000, 16'h0000);
            end
            clear_parser();
        end
        if (fire)
            s5_results_due.push_back(res);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Acceptance on both channels is seen here, before the block updates.
    always @(posedge i_clk) begin
        t_result want;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                parse_table_byte(i_data_byte, i_last_byte);
                moved = 1'b1;
            end
            if (o_valid === 1'b1 && !i_stall) begin
                moved = 1'b1;
                if (s5_results_due.size() == 0) begin
                    $display("%0t: unexpected result, got status %h a %h b %h", $time,
                             o_parse_status, o_sleep_type_a, o_sleep_type_b);
                    mismatch_count++;
                end else begin
                    want = s5_results_due.pop_front();
                    check_field("parse_status", {14'd0, want.parse_status},
                                {14'd0, o_parse_status});
                    check_field("sleep_type_a", want.sleep_type_a, o_sleep_type_a);
                    check_field("sleep_type_b", want.sleep_type_b, o_sleep_type_b);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_stall   = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("FAIL sleep_package_byte_parser_unit");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word
    // is taken, with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_table();
        for (int i = 0; i < table_bytes.size(); i++)
            send_byte(table_bytes[i], i == table_bytes.size() - 1);
    endtask

    task automatic wait_for_results();
        i_valid = 1'b0;
        while (s5_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic add_package_value();
        case ($urandom_range(2))
            0: begin
                table_bytes.push_back(BYTE_PREFIX);
                table_bytes.push_back(8'($urandom));
            end
            1: begin
                table_bytes.push_back(WORD_PREFIX);
                table_bytes.push_back(8'($urandom));
                table_bytes.push_back(8'($urandom));
            end
            default: table_bytes.push_back(8'($urandom));
        endcase
    endtask

    // Mostly well-formed S5 packages with random content, some cut short,
    // some with a wrong opcode after the name, and the rest plain noise.
    task automatic build_random_table();
        logic [7:0] lead;
        int         keep;
        table_bytes.delete();
        if ($urandom_range(99) < 70) begin
            repeat ($urandom_range(3)) table_bytes.push_back(8'($urandom));
            table_bytes.push_back(NAME_OP);
            if ($urandom_range(1) == 1)
                table_bytes.push_back(ROOT_CHAR);
            table_bytes.push_back(CHAR_US);
            table_bytes.push_back(CHAR_S);
            table_bytes.push_back(CHAR_5);
            table_bytes.push_back(CHAR_US);
            if ($urandom_range(9) == 0)
                table_bytes.push_back(8'($urandom));
            else
                table_bytes.push_back(PACKAGE_OP);
            lead = 8'($urandom);
            table_bytes.push_back(lead);
            repeat (lead[7:6]) table_bytes.push_back(8'($urandom));
            table_bytes.push_back(8'($urandom));
            add_package_value();
            add_package_value();
            repeat ($urandom_range(3)) table_bytes.push_back(8'($urandom));
            if ($urandom_range(99) < 35) begin
                keep = $urandom_range(table_bytes.size(), 1);
                while (table_bytes.size() > keep)
                    void'(table_bytes.pop_back());
            end
        end else begin
            repeat ($urandom_range(8, 1)) table_bytes.push_back(8'($urandom));
            if ($urandom_range(1) == 1) begin
                table_bytes.push_back(NAME_OP);
                table_bytes.push_back(CHAR_US);
                table_bytes.push_back(CHAR_S);
                table_bytes.push_back(8'($urandom));
            end
        end
    endtask

    task automatic test_directed_tables();
        // One byte table, all ones: nothing to find.
        table_bytes = '{8'hFF};
        send_table();
        // Word then bare value; the byte after the result gives nothing.
        table_bytes = '{NAME_OP, CHAR_US, CHAR_S, CHAR_5, CHAR_US, PACKAGE_OP, 8'h00,
                        8'h02, WORD_PREFIX, 8'h34, 8'h12, 8'hFF, 8'h00};
        send_table();
        // Root prefix, three extra length bytes, table ends inside the
        // second value.
        table_bytes = '{NAME_OP, ROOT_CHAR, CHAR_US, CHAR_S, CHAR_5, CHAR_US, PACKAGE_OP,
                        8'hC0, 8'h01, 8'h02, 8'h03, 8'h02, BYTE_PREFIX, 8'h80,
                        WORD_PREFIX};
        send_table();
        // Name followed by something other than the package opcode.
        table_bytes = '{NAME_OP, CHAR_US, CHAR_S, CHAR_5, CHAR_US, 8'h13, 8'h00};
        send_table();
        wait_for_results();
    endtask

    task automatic test_random_tables(input int idle_pct, input int stall_in, input int words);
        int stop_at;
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        stop_at       = bytes_sent + words;
        while (bytes_sent < stop_at) begin
            build_random_table();
            send_table();
        end
        wait_for_results();
    endtask

    // The receiver holds off while one-byte tables keep coming, so the
    // block fills and stalls its input.
    task automatic test_receiver_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = HOLD_CYCLES;
        repeat (30) begin
            table_bytes = '{8'($urandom)};
            send_table();
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        clear_parser();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_tables();
        test_random_tables(0, 0, 180);
        test_random_tables(47, 0, 180);
        test_random_tables(0, 47, 180);
        test_random_tables(23, 23, 180);
        test_receiver_hold();

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && s5_results_due.size() == 0) begin
            $display("PASS sleep_package_byte_parser_unit");
        end else begin
            $display("FAIL sleep_package_byte_parser_unit");
        end
        $finish;
    end

endmodule
